>>> rtl/tad_pkg.sv
// Package: phase and register codes, timing constants and the arcsine angle table.
package tad_pkg;

  localparam int DEFAULT_SAMPLE_RATE_HZ = 100;

  localparam int UPRIGHT_MS        = 8000;
  localparam int COUNT_TIMEOUT_MS  = 5000;
  localparam int COUNT_SHAKE_MS    = 3000;
  localparam int TILT_VALID_MS     = 1500;
  localparam int STATIC_SHAKE_MS   = 5000;
  localparam int MS_PER_SECOND     = 1000;
  localparam int ALARM_SECONDS_MAX = 1800;
  localparam int STATIC_TIMEOUT_MS = (ALARM_SECONDS_MAX + 1) * MS_PER_SECOND;

  localparam int UPRIGHT_MIN_ANGLE = 60;
  localparam int TABLE_LEN         = 91;

  localparam int ANGLE_W     = 7;
  localparam int ANGLE_LIM_W = 6;
  localparam int SECONDS_W   = 11;
  localparam int AXIS_W      = 2;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 11;

  typedef enum logic [1:0] {
    PH_PREPARE = 2'd0,
    PH_COUNT   = 2'd1,
    PH_STATIC  = 2'd2,
    PH_REBACK  = 2'd3
  } phase_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_ANGLE_LIMIT   = 2'd0,
    CFG_ALARM_SECONDS = 2'd1,
    CFG_AXIS_SELECT   = 2'd2
  } cfg_index_t;

  typedef enum logic [AXIS_W-1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  localparam logic [8:0] ARCSIN_TAB [TABLE_LEN] = '{
    9'd0,   9'd9,   9'd18,  9'd27,  9'd36,  9'd45,  9'd53,  9'd62,  9'd71,  9'd80,
    9'd89,  9'd98,  9'd106, 9'd115, 9'd124, 9'd132, 9'd141, 9'd150, 9'd158, 9'd167,
    9'd175, 9'd183, 9'd192, 9'd200, 9'd208, 9'd216, 9'd224, 9'd232, 9'd240, 9'd248,
    9'd256, 9'd264, 9'd271, 9'd279, 9'd286, 9'd294, 9'd301, 9'd308, 9'd315, 9'd322,
    9'd329, 9'd336, 9'd342, 9'd349, 9'd356, 9'd362, 9'd368, 9'd374, 9'd380, 9'd386,
    9'd392, 9'd398, 9'd403, 9'd409, 9'd414, 9'd419, 9'd424, 9'd429, 9'd434, 9'd439,
    9'd443, 9'd448, 9'd452, 9'd456, 9'd460, 9'd464, 9'd468, 9'd471, 9'd475, 9'd476,
    9'd478, 9'd479, 9'd480, 9'd481, 9'd482, 9'd484, 9'd485, 9'd486, 9'd487, 9'd489,
    9'd490, 9'd491, 9'd492, 9'd493, 9'd494, 9'd495, 9'd496, 9'd497, 9'd498, 9'd499,
    9'd500
  };

  function automatic logic [ANGLE_W-1:0] angle_of(input logic [15:0] mag);
    logic [ANGLE_W-1:0] a;
    a = '0;
    for (int i = 0; i < TABLE_LEN; i++) begin
      if (mag >= {7'd0, ARCSIN_TAB[i]}) begin
        a = ANGLE_W'(i);
      end
    end
    return a;
  endfunction

endpackage

>>> rtl/accel_tilt_alarm_detector.sv
// Top level: tilt alarm detector with sample register, phase machine and result register.
//
// Usage:
//   Sample channel: accel_x/y/z and still_flag move on sample_valid with
//   sample_stall low. Result channel: alarm, phase and tilt_angle move on
//   result_valid with result_stall low. One result per sample, in order.
//   Configuration: cfg_index/cfg_data written when cfg_valid and cfg_ready
//   are high; cfg_ready is always high. Write only while the block is idle.
//   Path: a sample taken into the sample register passes through the phase
//   machine, and its result is held in the result register until it is taken.
//   Throughput: one sample per cycle while results are not stalled, set by the
//   combinational phase machine update (angle table compare plus counter compare) between the registers.
//   Stall: while result_stall holds a pending result, the sample register
//   still takes one more sample; then sample_stall rises until the result
//   is taken.
//   Reset: rst (synchronous) empties both registers, returns the machine to
//   prepare with all counters cleared and loads angle limit 45, alarm
//   seconds 5 and the x axis.
module accel_tilt_alarm_detector
  import tad_pkg::*;
#(
  parameter int SAMPLE_RATE_HZ = DEFAULT_SAMPLE_RATE_HZ
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   sample_valid,
  output logic                   sample_stall,
  input  logic signed [15:0]     accel_x,
  input  logic signed [15:0]     accel_y,
  input  logic signed [15:0]     accel_z,
  input  logic                   still_flag,
  output logic                   result_valid,
  input  logic                   result_stall,
  output logic                   alarm,
  output logic [1:0]             phase,
  output logic [ANGLE_W-1:0]     tilt_angle,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int MS_PER_SAMPLE  = 1000 / SAMPLE_RATE_HZ;
  localparam int UPRIGHT_LIM    = UPRIGHT_MS / MS_PER_SAMPLE;
  localparam int COUNT_TO_LIM   = COUNT_TIMEOUT_MS / MS_PER_SAMPLE;
  localparam int COUNT_SHK_LIM  = COUNT_SHAKE_MS / MS_PER_SAMPLE;
  localparam int TILT_VALID_LIM = TILT_VALID_MS / MS_PER_SAMPLE;
  localparam int STATIC_SHK_LIM = STATIC_SHAKE_MS / MS_PER_SAMPLE;
  localparam int STATIC_TO_LIM  = STATIC_TIMEOUT_MS / MS_PER_SAMPLE;

  localparam int UW = $clog2(UPRIGHT_LIM + 2);
  localparam int TW = $clog2(STATIC_TO_LIM + 1);
  localparam int SW = $clog2(((STATIC_SHK_LIM > COUNT_SHK_LIM) ?
                              STATIC_SHK_LIM : COUNT_SHK_LIM) + 1);
  localparam int VW = $clog2(TILT_VALID_LIM + 1);
  localparam int CW = $clog2(((1 << SECONDS_W) - 1) * MS_PER_SECOND
                             + STATIC_TO_LIM * MS_PER_SAMPLE + MS_PER_SAMPLE + 1);

  logic                   smp_valid;
  logic signed [15:0]     smp_x;
  logic signed [15:0]     smp_y;
  logic signed [15:0]     smp_z;
  logic                   smp_still;

  logic [ANGLE_LIM_W-1:0] angle_limit;
  logic [SECONDS_W-1:0]   alarm_seconds;
  logic [AXIS_W-1:0]      axis_select;

  phase_t                 phase_reg;
  phase_t                 phase_next;
  logic                   upright_seen;
  logic                   upright_seen_next;
  logic [UW-1:0]          upright_count;
  logic [UW-1:0]          upright_count_next;
  logic [TW-1:0]          timeout_count;
  logic [TW-1:0]          timeout_count_next;
  logic [SW-1:0]          shake_count;
  logic [SW-1:0]          shake_count_next;
  logic [VW-1:0]          tilt_valid_count;
  logic [VW-1:0]          tilt_valid_count_next;
  logic [TW-1:0]          tilt_hold_count;
  logic [TW-1:0]          tilt_hold_count_next;
  logic                   alarm_next;

  logic                   advance;
  logic                   accept;
  logic signed [15:0]     sel;
  logic [15:0]            mag;
  logic [ANGLE_W-1:0]     angle;
  logic                   tilted;
  logic                   upright;
  logic                   shaky;
  logic [UW-1:0]          upright_inc;
  logic [TW-1:0]          timeout_inc;
  logic [SW-1:0]          shake_inc;
  logic [VW-1:0]          tilt_valid_inc;
  logic [TW-1:0]          tilt_hold_inc;
  logic [CW-1:0]          hold_span;
  logic [CW-1:0]          alarm_span;
  logic                   alarm_hit;

  assign advance      = smp_valid && (!result_valid || !result_stall);
  assign sample_stall = smp_valid && !advance;
  assign accept       = sample_valid && !sample_stall;
  assign cfg_ready    = 1'b1;

  // sample register
  always_ff @(posedge clk) begin
    if (rst) begin
      smp_valid <= 1'b0;
    end else if (accept) begin
      smp_valid <= 1'b1;
    end else if (advance) begin
      smp_valid <= 1'b0;
    end
    if (accept) begin
      smp_x     <= accel_x;
      smp_y     <= accel_y;
      smp_z     <= accel_z;
      smp_still <= still_flag;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      angle_limit   <= ANGLE_LIM_W'(45);
      alarm_seconds <= SECONDS_W'(5);
      axis_select   <= AXIS_X;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ANGLE_LIMIT:   angle_limit   <= cfg_data[ANGLE_LIM_W-1:0];
        CFG_ALARM_SECONDS: alarm_seconds <= cfg_data[SECONDS_W-1:0];
        CFG_AXIS_SELECT:   axis_select   <= cfg_data[AXIS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (axis_select)
      AXIS_Y:  sel = smp_y;
      AXIS_Z:  sel = smp_z;
      default: sel = smp_x;
    endcase
  end

  assign mag     = sel[15] ? 16'(~sel + 16'sd1) : 16'(sel);
  assign angle   = angle_of(mag);
  assign tilted  = angle <= {1'b0, angle_limit};
  assign upright = angle > ANGLE_W'(UPRIGHT_MIN_ANGLE);
  assign shaky   = !smp_still || !tilted;

  assign upright_inc    = upright_count + UW'(1);
  assign timeout_inc    = timeout_count + TW'(1);
  assign shake_inc      = shake_count + SW'(1);
  assign tilt_valid_inc = (smp_still ? tilt_valid_count : '0) + VW'(1);
  assign tilt_hold_inc  = (shaky ? '0 : tilt_hold_count) + TW'(1);

  // count >= floor(seconds * 1000 / ms_per_sample) <=> (count + 1) * ms > seconds * 1000
  assign hold_span  = (CW'(tilt_hold_inc) + CW'(1)) * CW'(MS_PER_SAMPLE);
  assign alarm_span = CW'(alarm_seconds) * CW'(MS_PER_SECOND);
  assign alarm_hit  = hold_span > alarm_span;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg        <= PH_PREPARE;
      upright_seen     <= 1'b0;
      upright_count    <= '0;
      timeout_count    <= '0;
      shake_count      <= '0;
      tilt_valid_count <= '0;
      tilt_hold_count  <= '0;
    end else if (advance) begin
      phase_reg        <= phase_next;
      upright_seen     <= upright_seen_next;
      upright_count    <= upright_count_next;
      timeout_count    <= timeout_count_next;
      shake_count      <= shake_count_next;
      tilt_valid_count <= tilt_valid_count_next;
      tilt_hold_count  <= tilt_hold_count_next;
    end
  end

  always_comb begin
    phase_next            = phase_reg;
    upright_seen_next     = upright_seen;
    upright_count_next    = upright_count;
    timeout_count_next    = timeout_count;
    shake_count_next      = shake_count;
    tilt_valid_count_next = tilt_valid_count;
    tilt_hold_count_next  = tilt_hold_count;
    alarm_next            = 1'b0;
    case (phase_reg)
      PH_PREPARE: begin
        if (upright_seen) begin
          if (tilted) begin
            phase_next            = PH_COUNT;
            timeout_count_next    = '0;
            shake_count_next      = '0;
            tilt_valid_count_next = '0;
            upright_seen_next     = 1'b0;
          end
        end else if (upright) begin
          if (upright_inc > UW'(UPRIGHT_LIM)) begin
            upright_count_next = '0;
            upright_seen_next  = 1'b1;
          end else begin
            upright_count_next = upright_inc;
          end
        end else begin
          upright_count_next = '0;
        end
      end
      PH_COUNT: begin
        timeout_count_next = timeout_inc;
        if (timeout_inc >= TW'(COUNT_TO_LIM)) begin
          phase_next = PH_REBACK;
        end else if (!smp_still && shake_inc >= SW'(COUNT_SHK_LIM)) begin
          shake_count_next = shake_inc;
          phase_next       = PH_REBACK;
        end else begin
          if (!smp_still) begin
            shake_count_next = shake_inc;
          end
          if (tilted) begin
            tilt_valid_count_next = tilt_valid_inc;
            if (tilt_valid_inc >= VW'(TILT_VALID_LIM)) begin
              phase_next           = PH_STATIC;
              tilt_hold_count_next = '0;
              shake_count_next     = '0;
              timeout_count_next   = '0;
            end
          end else begin
            tilt_valid_count_next = '0;
          end
        end
      end
      PH_STATIC: begin
        timeout_count_next = timeout_inc;
        if (timeout_inc >= TW'(STATIC_TO_LIM)) begin
          phase_next = PH_REBACK;
        end else if (shaky && shake_inc >= SW'(STATIC_SHK_LIM)) begin
          shake_count_next = shake_inc;
          phase_next       = PH_REBACK;
        end else begin
          shake_count_next     = shaky ? shake_inc : '0;
          tilt_hold_count_next = tilt_hold_inc;
          if (alarm_hit) begin
            alarm_next = 1'b1;
            phase_next = PH_REBACK;
          end
        end
      end
      default: begin
        phase_next            = PH_PREPARE;
        upright_seen_next     = 1'b0;
        upright_count_next    = '0;
        timeout_count_next    = '0;
        shake_count_next      = '0;
        tilt_valid_count_next = '0;
        tilt_hold_count_next  = '0;
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
    if (advance) begin
      alarm      <= alarm_next;
      phase      <= phase_next;
      tilt_angle <= angle;
    end
  end

`ifndef SYNTHESIS
  a_alarm_ends_static: assert property (@(posedge clk) disable iff (rst)
    result_valid && alarm |-> phase == PH_REBACK)
    else $error("alarm result without reback phase");

  a_prepare_no_skip: assert property (@(posedge clk) disable iff (rst)
    advance && phase_reg == PH_PREPARE |=>
      phase_reg == PH_PREPARE || phase_reg == PH_COUNT)
    else $error("prepare left for a phase other than count");

  a_reback_clears: assert property (@(posedge clk) disable iff (rst)
    advance && phase_reg == PH_REBACK |=>
      phase_reg == PH_PREPARE && !upright_seen && upright_count == '0 &&
      timeout_count == '0 && tilt_hold_count == '0)
    else $error("reback did not clear state");

  a_stall_needs_sample: assert property (@(posedge clk) disable iff (rst)
    sample_stall |-> smp_valid && result_valid && result_stall)
    else $error("sample stall without a blocked result");
`endif

endmodule
